@@ hw/rtl/open_addressing_hash_table_unit_macros.svh @@
// Assertion shorthands for the hash table unit; clock and reset are the
// port names of the unit.
`ifndef OPEN_ADDRESSING_HASH_TABLE_UNIT_MACROS_SVH
`define OPEN_ADDRESSING_HASH_TABLE_UNIT_MACROS_SVH

// Checked outside reset only.
`define OAHT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked at every edge, reset included.
`define OAHT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hw/rtl/oaht_pkg.sv @@
`default_nettype none
package oaht_pkg;

   localparam int TABLE_SIZE_DEF = 16;
   localparam int KEY_BITS_DEF   = 32;

   typedef enum logic [1:0] {
      SLOT_EMPTY = 2'd0,
      SLOT_USED  = 2'd1,
      SLOT_GONE  = 2'd2
   } slot_type;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_FIND   = 2'd1,
      MODE_DELETE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_DUP     = 2'd1,
      STAT_MISSING = 2'd2,
      STAT_FULL    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_SEEK_RD,
      S_SEEK_CHK,
      S_FREE_RD,
      S_FREE_CHK,
      S_RESP
   } state_type;

endpackage
`default_nettype wire

@@ hw/rtl/open_addressing_hash_table_unit.sv @@
`default_nettype none
// Linear-probing hash table of TABLE_SIZE keys with tombstones. A request word
// carries a mode (insert, find, delete) and a key; every request returns one
// response word with a status and the slot used or found (slot is zero unless
// status is ok). After reset the block clears the slot states in turn and
// holds req_stall meanwhile. The idle state takes a request word; then, for
// each 16-bit key chunk, to reach the home slot, a reciprocal multiply gives
// the chunk quotient, then a multiply and subtract leaves the remainder. Each
// slot probed takes a registered table read, then the key compare, and a last
// step loads the response register. Up to TABLE_SIZE slots are probed for find
// and delete and up to 2*TABLE_SIZE for insert (duplicate check, then
// free-slot search). The block takes no new request word until the last one's
// response register is loaded. The response register lets the next request
// start while the previous response is still stalled.
module open_addressing_hash_table_unit #(
   parameter int TABLE_SIZE = oaht_pkg::TABLE_SIZE_DEF,
   parameter int KEY_BITS   = oaht_pkg::KEY_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_mode,
   input  wire logic [31:0]          req_key,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output oaht_pkg::status_type      rsp_status,
   output logic [3:0]                rsp_slot
);
   import oaht_pkg::*;

   localparam int IW     = $clog2(TABLE_SIZE);
   localparam int CHUNK  = 16;
   localparam int NCHUNK = (KEY_BITS + CHUNK - 1) / CHUNK;
   localparam int SW     = NCHUNK * CHUNK;
   localparam int NW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int XW     = IW + CHUNK;
   localparam int QS     = XW + IW;
   localparam logic [IW-1:0] LAST   = IW'(TABLE_SIZE - 1);
   localparam logic [IW:0]   SIZE_W = (IW + 1)'(TABLE_SIZE);
   localparam logic [63:0]   SIZE_L = 64'(TABLE_SIZE);
   // ceil(2^QS / TABLE_SIZE): exact quotient for any XW-bit dividend
   localparam logic [XW:0]   RECIP  = (XW + 1)'(((64'd1 << QS) + SIZE_L - 64'd1) / SIZE_L);

   state_type             state_ff, state_in;
   logic [1:0]            mode_ff, mode_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [SW-1:0]         shift_ff, shift_in;
   logic [NW-1:0]         chunk_ff, chunk_in;
   logic                  phase_ff, phase_in;
   logic [CHUNK-1:0]      quo_ff, quo_in;
   logic [IW-1:0]         home_ff, home_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [IW-1:0]         cnt_ff, cnt_in;
   status_type            res_status_ff, res_status_in;
   logic [IW-1:0]         res_slot_ff, res_slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [3:0]            rsp_slot_ff, rsp_slot_in;

   slot_type              state_mem [TABLE_SIZE];
   logic [KEY_BITS-1:0]   key_mem [TABLE_SIZE];
   slot_type              rd_state_ff;
   logic [KEY_BITS-1:0]   rd_key_ff;
   logic                  st_we;
   slot_type              st_wdata;
   logic                  key_we;

   logic [XW-1:0]         dvd;
   logic [2*XW:0]         prod;
   logic [XW:0]           qn;
   logic [XW-1:0]         rem_full;
   logic [IW-1:0]         rem_next;
   logic [IW-1:0]         next_idx;
   logic                  hit;
   logic [IW+3:0]         slot_ext;

   // running remainder in front of the next key chunk
   assign dvd      = {home_ff, shift_ff[SW-1 -: CHUNK]};
   assign prod     = {{(XW + 1){1'b0}}, dvd} * {{XW{1'b0}}, RECIP};
   assign qn       = {{(IW + 1){1'b0}}, quo_ff} * {{CHUNK{1'b0}}, SIZE_W};
   assign rem_full = dvd - qn[XW-1:0];
   assign rem_next = rem_full[IW-1:0];
   assign next_idx = (idx_ff == LAST) ? '0 : idx_ff + 1'b1;
   assign hit      = (rd_state_ff == SLOT_USED) && (rd_key_ff == key_ff);
   assign slot_ext = {4'b0000, res_slot_ff};

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;

   always_ff @(posedge clock) begin
      if (st_we) begin
         state_mem[idx_ff] <= st_wdata;
      end
      if (key_we) begin
         key_mem[idx_ff] <= key_ff;
      end
      rd_state_ff <= state_mem[idx_ff];
      rd_key_ff   <= key_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      shift_ff      <= shift_in;
      chunk_ff      <= chunk_in;
      phase_ff      <= phase_in;
      quo_ff        <= quo_in;
      home_ff       <= home_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      shift_in      = shift_ff;
      chunk_in      = chunk_ff;
      phase_in      = phase_ff;
      quo_in        = quo_ff;
      home_in       = home_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      st_we         = 1'b0;
      st_wdata      = SLOT_EMPTY;
      key_we        = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            st_we    = 1'b1;
            st_wdata = SLOT_EMPTY;
            idx_in   = next_idx;
            if (idx_ff == LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               key_in   = KEY_BITS'(req_key);
               shift_in = SW'(key_in);
               chunk_in = NW'(NCHUNK - 1);
               phase_in = 1'b0;
               home_in  = '0;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (!phase_ff) begin
               quo_in   = prod[QS +: CHUNK];
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               home_in  = rem_next;
               shift_in = shift_ff << CHUNK;
               chunk_in = chunk_ff - 1'b1;
               if (chunk_ff == '0) begin
                  idx_in = rem_next;
                  cnt_in = '0;
                  if (mode_ff == MODE_INSERT || mode_ff == MODE_FIND ||
                      mode_ff == MODE_DELETE) begin
                     state_in = S_SEEK_RD;
                  end else begin
                     res_status_in = STAT_MISSING;
                     res_slot_in   = '0;
                     state_in      = S_RESP;
                  end
               end
            end
         end
         S_SEEK_RD: begin
            state_in = S_SEEK_CHK;
         end
         S_SEEK_CHK: begin
            if (hit) begin
               state_in = S_RESP;
               if (mode_ff == MODE_INSERT) begin
                  res_status_in = STAT_DUP;
                  res_slot_in   = '0;
               end else begin
                  res_status_in = STAT_OK;
                  res_slot_in   = idx_ff;
                  if (mode_ff == MODE_DELETE) begin
                     st_we    = 1'b1;
                     st_wdata = SLOT_GONE;
                  end
               end
            end else if (rd_state_ff == SLOT_EMPTY || cnt_ff == LAST) begin
               // key absent: insert goes on to look for a free slot
               if (mode_ff == MODE_INSERT) begin
                  idx_in   = home_ff;
                  cnt_in   = '0;
                  state_in = S_FREE_RD;
               end else begin
                  res_status_in = STAT_MISSING;
                  res_slot_in   = '0;
                  state_in      = S_RESP;
               end
            end else begin
               idx_in   = next_idx;
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_SEEK_RD;
            end
         end
         S_FREE_RD: begin
            state_in = S_FREE_CHK;
         end
         S_FREE_CHK: begin
            if (rd_state_ff != SLOT_USED) begin
               st_we         = 1'b1;
               st_wdata      = SLOT_USED;
               key_we        = 1'b1;
               res_status_in = STAT_OK;
               res_slot_in   = idx_ff;
               state_in      = S_RESP;
            end else if (cnt_ff == LAST) begin
               res_status_in = STAT_FULL;
               res_slot_in   = '0;
               state_in      = S_RESP;
            end else begin
               idx_in   = next_idx;
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_FREE_RD;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = slot_ext[3:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ hw/rtl/oaht_checker.sv @@
`default_nettype none
`include "open_addressing_hash_table_unit_macros.svh"
module oaht_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire oaht_pkg::status_type rsp_status,
   input wire logic [3:0]           rsp_slot
);
   import oaht_pkg::*;

   logic       req_word;
   logic       rsp_held;
   logic       rsp_fail;
   logic [5:0] rsp_word;
   assign req_word = req_valid && !req_stall;
   assign rsp_held = rsp_valid && rsp_stall;
   assign rsp_fail = rsp_valid && (rsp_status != STAT_OK);
   assign rsp_word = {rsp_status, rsp_slot};

   // reset starts the clearing pass and drops any response
   `OAHT_ASSERT_ALWAYS(a_reset_clears, reset |=> req_stall && !rsp_valid, "reset not honored")

   // one request at a time: busy right after a word is taken
   `OAHT_ASSERT(a_busy_after_req, req_word |=> req_stall, "request taken while busy")

   `OAHT_ASSERT(a_slot_zero, rsp_fail |-> rsp_slot == 4'd0, "slot set on failure")

   `OAHT_ASSERT(a_rsp_hold, rsp_held |=> rsp_valid && $stable(rsp_word), "stalled word changed")

endmodule

bind open_addressing_hash_table_unit oaht_checker u_oaht_checker (.*);
`default_nettype wire

@@ tb/sv/tb_open_addressing_hash_table_unit.sv @@
`default_nettype none
module tb_open_addressing_hash_table_unit;
   import oaht_pkg::*;

   localparam int SLOTS       = TABLE_SIZE_DEF;
   localparam int ITEMS       = 1050;
   localparam int QUIET_TAIL  = 150;
   localparam int POOL_N      = 24;
   localparam int HOLD_CYCLES = 600;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_WAIT  = 120;
   localparam logic [1:0] MODE_SPARE = 2'd3;   // not decoded by the block

   typedef struct packed {
      status_type status;
      logic [3:0] slot;
   } reply_type;

   // Mirror of the table plus the replies still owed by the block.
   class hash_table_scoreboard_type;
      slot_type    kind [SLOTS];
      logic [31:0] held [SLOTS];
      reply_type   replies_due [$];
      int          mismatches;
      int          checked;

      function new();
         foreach (kind[i]) begin
            kind[i] = SLOT_EMPTY;
            held[i] = '0;
         end
         mismatches = 0;
         checked = 0;
      endfunction

      // Probe from home until an empty slot or a full lap; tombstones are skipped.
      function bit locate(logic [31:0] key, output int at);
         int j;
         int n;
         at = 0;
         j = key % SLOTS;
         for (n = 0; n < SLOTS && kind[j] != SLOT_EMPTY; n++) begin
            if (kind[j] == SLOT_USED && held[j] == key) begin
               at = j;
               return 1'b1;
            end
            j = (j + 1) % SLOTS;
         end
         return 1'b0;
      endfunction

      function void note_request(logic [1:0] mode, logic [31:0] key);
         reply_type r;
         int        at;
         int        j;
         int        n;
         bit        hit;
         r.status = STAT_MISSING;
         r.slot = '0;
         hit = locate(key, at);
         case (mode)
            MODE_INSERT: begin
               if (hit) begin
                  r.status = STAT_DUP;
               end else begin
                  j = key % SLOTS;
                  n = 0;
                  while (n < SLOTS && kind[j] == SLOT_USED) begin
                     j = (j + 1) % SLOTS;
                     n++;
                  end
                  if (n < SLOTS) begin
                     kind[j] = SLOT_USED;
                     held[j] = key;
                     r.status = STAT_OK;
                     r.slot = 4'(j);
                  end else begin
                     r.status = STAT_FULL;
                  end
               end
            end
            MODE_FIND: begin
               if (hit) begin
                  r.status = STAT_OK;
                  r.slot = 4'(at);
               end
            end
            MODE_DELETE: begin
               if (hit) begin
                  kind[at] = SLOT_GONE;
                  r.status = STAT_OK;
                  r.slot = 4'(at);
               end
            end
            default: ;
         endcase
         replies_due.push_back(r);
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%s", msg);
      endfunction

      function void check_response(status_type status, logic [3:0] slot);
         reply_type want;
         if (replies_due.size() == 0) begin
            report($sformatf("unexpected reply: status=%0d slot=%0d", status, slot));
            return;
         end
         want = replies_due.pop_front();
         if (status !== want.status || slot !== want.slot)
            report($sformatf("reply %0d: expected status=%0d slot=%0d, got status=%0d slot=%0d",
                             checked, want.status, want.slot, status, slot));
         checked++;
      endfunction

      function int pending();
         return replies_due.size();
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [1:0]       req_mode = '0;
   logic [31:0]      req_key = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   status_type       rsp_status;
   logic [3:0]       rsp_slot;

   hash_table_scoreboard_type table_model = new();

   int          sent = 0;
   bit          quiet = 1'b0;
   int          idle_count = 0;
   logic [31:0] pool [POOL_N];

   open_addressing_hash_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_mode   (req_mode),
      .req_key    (req_key),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_slot   (rsp_slot)
   );

   always #5 clock = ~clock;

   // Both channels sampled at the edge, before any of this edge's updates land.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            table_model.check_response(rsp_status, rsp_slot);
         if (req_valid === 1'b1 && req_stall === 1'b0)
            table_model.note_request(req_mode, req_key);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid === 1'b1 && req_stall === 1'b0)
                || (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         idle_count <= 0;
      end else if (idle_count >= STALL_LIMIT) begin
         $display("tb_open_addressing_hash_table_unit: FAIL");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   // Receiver: short random stalls, plus one long hold-off so the block backs up.
   initial begin : rsp_side
      bit held_off;
      held_off = 1'b0;
      @(posedge clock);
      forever begin
         if (!held_off && table_model.checked >= 120) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // Called at a rising edge; returns at the edge where the word is taken.
   task automatic send_request(input logic [1:0] mode, input logic [31:0] key);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_key   <= key;
      @(posedge clock);
      while (!(req_valid === 1'b1 && req_stall === 1'b0)) @(posedge clock);
      sent++;
      quiet = (sent >= ITEMS - QUIET_TAIL);
   endtask

   function automatic logic [31:0] fresh_key(int base, int spread);
      logic [31:0] k;
      k = $urandom;
      k[3:0] = 4'((base + $urandom_range(0, spread)) % SLOTS);
      return k;
   endfunction

   initial begin : req_side
      int          i;
      int          p;
      int          base;
      int          spread;
      int          ins_pct;
      int          find_pct;
      int          renew;
      int          span;
      int          roll;
      logic [1:0]  mode;
      logic [31:0] key;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Empty table: misses and the spare mode.
      send_request(MODE_FIND, 32'h0000_0000);
      send_request(MODE_DELETE, 32'hFFFF_FFFF);
      send_request(MODE_SPARE, 32'h0000_0005);
      // Duplicate, home collision and wrap-around past the last slot.
      send_request(MODE_INSERT, 32'h0000_0000);
      send_request(MODE_INSERT, 32'h0000_0000);
      send_request(MODE_INSERT, 32'h0000_0010);
      send_request(MODE_INSERT, 32'hFFFF_FFFF);
      send_request(MODE_INSERT, 32'h8000_000F);
      send_request(MODE_FIND, 32'h8000_000F);
      // Tombstone: find walks over it, insert reuses it.
      send_request(MODE_DELETE, 32'h0000_0010);
      send_request(MODE_FIND, 32'h8000_000F);
      send_request(MODE_INSERT, 32'h0000_0020);
      // Fill the rest, then overflow and a full-lap miss.
      for (i = 0; i < 12; i++) begin
         pool[i] = fresh_key(3 + i, 0);
         send_request(MODE_INSERT, pool[i]);
      end
      send_request(MODE_INSERT, 32'h1234_5673);
      send_request(MODE_FIND, 32'hDEAD_BEE7);

      pool[12] = 32'h0000_0000;
      pool[13] = 32'h0000_0020;
      pool[14] = 32'h8000_000F;
      pool[15] = 32'hFFFF_FFFF;
      for (i = 16; i < POOL_N; i++) pool[i] = fresh_key($urandom_range(0, 15), 3);

      // Rounds over a slowly changing key pool; keys dropped from it are
      // usually deleted first so the table keeps turning over.
      while (sent < ITEMS) begin
         base = $urandom_range(0, 15);
         case ($urandom_range(0, 3))
            0: spread = 0;
            1: spread = 1;
            2: spread = 3;
            default: spread = 15;
         endcase
         ins_pct  = $urandom_range(20, 70);
         find_pct = $urandom_range(10, 95 - ins_pct);
         renew    = $urandom_range(0, 8);
         for (i = 0; i < renew && sent < ITEMS; i++) begin
            p = $urandom_range(0, POOL_N - 1);
            if ($urandom_range(0, 3) != 0) send_request(MODE_DELETE, pool[p]);
            pool[p] = fresh_key(base, spread);
         end
         span = $urandom_range(20, 60);
         for (i = 0; i < span && sent < ITEMS; i++) begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0) key = $urandom;
            else key = pool[$urandom_range(0, POOL_N - 1)];
            if (roll < ins_pct) mode = MODE_INSERT;
            else if (roll < ins_pct + find_pct) mode = MODE_FIND;
            else if (roll < 98) mode = MODE_DELETE;
            else mode = MODE_SPARE;
            send_request(mode, key);
         end
      end

      req_valid <= 1'b0;
      while (table_model.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (table_model.mismatches == 0 && table_model.pending() == 0) begin
         $display("tb_open_addressing_hash_table_unit: PASS");
      end else begin
         $display("tb_open_addressing_hash_table_unit: FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/oaht_pkg.sv
hw/rtl/open_addressing_hash_table_unit.sv
hw/rtl/oaht_checker.sv
tb/sv/tb_open_addressing_hash_table_unit.sv
